### design/sweep_object_segmenter_core_macros.svh
// Assertion macros used by the segmenter checker.
`ifndef SWEEP_OBJECT_SEGMENTER_CORE_MACROS_SVH
`define SWEEP_OBJECT_SEGMENTER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SOS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define SOS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/sos_pkg.sv
// Types and constants of the sweep object segmenter.
package sos_pkg;

  localparam int ANGLE_W    = 9;
  localparam int ENTRY_W    = 7;
  localparam int EXIT_W     = 8;
  localparam int HITS_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_PERCENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS      = 2'd2;

  localparam logic [ENTRY_W-1:0] ENTRY_PERCENT_RST = 7'd90;
  localparam logic [EXIT_W-1:0]  EXIT_PERCENT_RST  = 8'd110;
  localparam logic [HITS_W-1:0]  MIN_HITS_RST      = 8'd2;

  localparam logic [6:0]        SCALE_PCT = 7'd100;
  localparam logic [HITS_W-1:0] HITS_MAX  = 8'd255;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_percent;
    logic [EXIT_W-1:0]  exit_percent;
    logic [HITS_W-1:0]  min_hits;
  } cfg_t;

  typedef struct packed {
    logic open;
    logic hit;
    logic close;
  } decide_t;

endpackage

### design/sos_if.sv
// Valid/ready stream interfaces for samples and objects.
interface sos_in_if #(
  parameter int DIST_W = 14
);
  logic                        valid;
  logic                        ready;
  logic [DIST_W-1:0]           distance;
  logic [sos_pkg::ANGLE_W-1:0] angle;
  logic                        sweep_start;

  modport source (output valid, distance, angle, sweep_start, input ready);
  modport sink (input valid, distance, angle, sweep_start, output ready);
endinterface

interface sos_out_if #(
  parameter int DIST_W = 14
);
  logic                        valid;
  logic                        ready;
  logic [sos_pkg::ANGLE_W-1:0] start_angle;
  logic [sos_pkg::ANGLE_W-1:0] width_angle;
  logic [DIST_W-1:0]           object_distance;

  modport source (output valid, start_angle, width_angle, object_distance, input ready);
  modport sink (input valid, start_angle, width_angle, object_distance, output ready);
endinterface

### design/sos_cfg_regs.sv
// Configuration registers of the segmenter.
module sos_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sos_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output sos_pkg::cfg_t                      cfg
);

  sos_pkg::cfg_t cfg_r;
  sos_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        sos_pkg::CFG_ENTRY_PERCENT: cfg_nxt.entry_percent = cfg_wdata[sos_pkg::ENTRY_W-1:0];
        sos_pkg::CFG_EXIT_PERCENT:  cfg_nxt.exit_percent  = cfg_wdata[sos_pkg::EXIT_W-1:0];
        sos_pkg::CFG_MIN_HITS:      cfg_nxt.min_hits      = cfg_wdata[sos_pkg::HITS_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_percent <= sos_pkg::ENTRY_PERCENT_RST;
      cfg_r.exit_percent  <= sos_pkg::EXIT_PERCENT_RST;
      cfg_r.min_hits      <= sos_pkg::MIN_HITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/sos_decide.sv
// Barrier products and edge decisions for one sample.
module sos_decide #(
  parameter int DIST_W = 14
) (
  input  sos_pkg::cfg_t          cfg,
  input  logic [DIST_W-1:0]      cur,
  input  logic [DIST_W-1:0]      prev,
  input  logic                   in_object,
  input  logic [DIST_W+6:0]      saved_barrier,
  output logic [DIST_W+6:0]      open_barrier,
  output sos_pkg::decide_t       dec
);

  localparam int BAR_W = DIST_W + 8;

  logic [BAR_W-1:0] scaled;
  logic [BAR_W-1:0] entry_bar;
  logic [BAR_W-1:0] exit_bar;
  logic [BAR_W-1:0] saved_ext;
  logic             prev_nz;

  always_comb begin
    scaled    = BAR_W'(cur) * BAR_W'(sos_pkg::SCALE_PCT);
    entry_bar = BAR_W'(prev) * BAR_W'(cfg.entry_percent);
    exit_bar  = BAR_W'(prev) * BAR_W'(cfg.exit_percent);
    saved_ext = BAR_W'(saved_barrier);
    prev_nz   = (prev != '0);

    dec.open  = prev_nz && (scaled < entry_bar);
    dec.hit   = prev_nz && !dec.open && in_object && (scaled < exit_bar) &&
                (scaled < saved_ext);
    dec.close = prev_nz && !dec.open && !dec.hit && in_object && (scaled > exit_bar);
  end

  assign open_barrier = entry_bar[DIST_W+6:0];

endmodule

### design/sweep_object_segmenter_core.sv
// Top level of the sweep object segmenter.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_chan  | in  | valid/ready        | distance, angle, sweep_start
//  out_chan | out | valid/ready        | start_angle, width_angle, object_distance
//  cfg      | in  | cfg_we, no wait    | cfg_idx, cfg_wdata
//
// One sample is taken per cycle unless the object register stalls; a sample
// passes an input register, then the decision logic updates the sweep state
// and loads the object register on the closing sample. Synchronous reset clears
// the stages and the sweep state and loads the register defaults. A stalled
// object register holds the input stage, which then drops in_chan.ready.
module sweep_object_segmenter_core #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sos_in_if.sink                         in_chan,
  sos_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sos_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DIST_W  = 6 + FRACTION_BITS;
  localparam int SAVED_W = DIST_W + 7;
  localparam int AW      = sos_pkg::ANGLE_W;

  sos_pkg::cfg_t    cfg;
  sos_pkg::decide_t dec;

  logic               in_valid_r;
  logic [DIST_W-1:0]  dist_r;
  logic [AW-1:0]      angle_r;
  logic               start_r;

  logic [DIST_W-1:0]  prev_r, prev_nxt;
  logic               in_object_r, in_object_nxt;
  logic [7:0]         hit_r, hit_nxt;
  logic [AW-1:0]      obj_start_r, obj_start_nxt;
  logic [SAVED_W-1:0] barrier_r, barrier_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [AW-1:0]      out_start_r;
  logic [AW-1:0]      out_width_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic [DIST_W-1:0]  prev_eff;
  logic               in_object_eff;
  logic [SAVED_W-1:0] barrier_eff;
  logic [SAVED_W-1:0] open_barrier;
  logic               advance;
  logic               emit;

  sos_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sos_decide #(
    .DIST_W (DIST_W)
  ) u_decide (
    .cfg           (cfg),
    .cur           (dist_r),
    .prev          (prev_eff),
    .in_object     (in_object_eff),
    .saved_barrier (barrier_eff),
    .open_barrier  (open_barrier),
    .dec           (dec)
  );

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // Clear sweep state ahead of a sweep start sample.
  assign prev_eff      = start_r ? '0 : prev_r;
  assign in_object_eff = start_r ? 1'b0 : in_object_r;
  assign barrier_eff   = start_r ? '0 : barrier_r;

  assign emit = dec.close && (hit_r >= cfg.min_hits);

  always_comb begin
    prev_nxt      = dist_r;
    in_object_nxt = in_object_eff;
    hit_nxt       = start_r ? '0 : hit_r;
    obj_start_nxt = start_r ? '0 : obj_start_r;
    barrier_nxt   = barrier_eff;
    if (dec.open) begin
      in_object_nxt = 1'b1;
      hit_nxt       = 8'd1;
      obj_start_nxt = angle_r;
      barrier_nxt   = open_barrier;
    end else if (dec.hit) begin
      if (hit_r != sos_pkg::HITS_MAX) begin
        hit_nxt = hit_r + 8'd1;
      end
    end else if (dec.close) begin
      in_object_nxt = 1'b0;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = emit;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      in_object_r <= 1'b0;
      hit_r       <= '0;
      obj_start_r <= '0;
      barrier_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        prev_r      <= prev_nxt;
        in_object_r <= in_object_nxt;
        hit_r       <= hit_nxt;
        obj_start_r <= obj_start_nxt;
        barrier_r   <= barrier_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      dist_r  <= in_chan.distance;
      angle_r <= in_chan.angle;
      start_r <= in_chan.sweep_start;
    end
    if (advance && emit) begin
      out_start_r <= obj_start_r;
      out_width_r <= angle_r - obj_start_r;
      out_dist_r  <= prev_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.start_angle     = out_start_r;
  assign out_chan.width_angle     = out_width_r;
  assign out_chan.object_distance = out_dist_r;

endmodule

### design/sos_checker.sv
// Port-level checker of the segmenter top level and its bind.
`include "sweep_object_segmenter_core_macros.svh"

module sos_checker #(
  parameter int DIST_W = 14
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sos_pkg::ANGLE_W-1:0] out_start_angle,
  input logic [sos_pkg::ANGLE_W-1:0] out_width_angle,
  input logic [DIST_W-1:0]           out_object_distance
);

  `SOS_ASSERT_NXT_ALWAYS(a_reset_empties_out, clk, !rst_n, !out_valid, "item out after reset")

  `SOS_ASSERT_IMP(a_ready_when_out_free, clk, rst_n, !out_valid || out_ready, in_ready, "input held while output free")

  `SOS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_start_angle) && $stable(out_width_angle) && $stable(out_object_distance), "stalled item changed")

endmodule

bind sweep_object_segmenter_core sos_checker #(
  .DIST_W (DIST_W)
) u_sos_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_start_angle     (out_chan.start_angle),
  .out_width_angle     (out_chan.width_angle),
  .out_object_distance (out_chan.object_distance)
);
